### design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // item kinds on in_tuser
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // read_value of a get that misses
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

endpackage
`default_nettype wire

### design/lkvc_slot_ram.sv
`default_nettype none
module lkvc_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 68
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/lru_key_value_cache_core.sv
`default_nettype none
// Fully associative key/value cache of ENTRIES slots with least-recently-used
// replacement. An item on the in_ stream is a get (in_tuser = 0) or a put
// (in_tuser = 1) with key and value; each item gives exactly one result item
// on the out_ stream carrying hit, read value, evicted flag and evicted key.
// Keys, values and ages live in one synchronous RAM with a read port and a
// write port; valid bits and the occupancy count are flops cleared by reset,
// so no clearing pass is needed. One item at a time: a scan pass reads every
// slot to find the hit, the first free slot and the oldest entry, then a
// read-modify-write pass rewrites every slot's age and the target slot. A get
// that misses, or a put that changes nothing, skips the second pass. Each
// pass goes through the RAM one slot per cycle. The next item is accepted
// while a finished result still waits on out_tready.
// capacity_in_use (byte address 0) may only be written while the cache is
// empty; other writes are dropped, only the low CAP_W bits of the write are
// kept, 0 is taken as 1 and values above ENTRIES as ENTRIES.
module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [63:0]       in_tdata,   // [31:0] lookup_key, [63:32] write_value
  input  wire logic              in_tuser,   // [0] opcode
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [63:0]            out_tdata,  // [31:0] read_value, [63:32] evicted_key
  output logic [1:0]             out_tuser,  // [0] hit, [1] evicted
  // register port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int WW      = KEY_W + VAL_W + IW;
  localparam int CAP_RST = (ENTRIES < 16) ? ENTRIES : 16;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // item being worked on
  logic             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;

  // slot sweep: read issue counter and the slot whose data comes back
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             issue;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      cap_r, cap_nxt;

  // scan findings
  logic             found_r, found_nxt;
  logic [IW-1:0]    fidx_r, fidx_nxt;
  logic [VAL_W-1:0] fval_r, fval_nxt;
  logic [IW-1:0]    fage_r, fage_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;
  logic             old_vld_r, old_vld_nxt;
  logic [IW-1:0]    oidx_r, oidx_nxt;
  logic [IW-1:0]    oage_r, oage_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;

  // update pass control: target slot, age threshold, age every valid slot
  logic [IW-1:0]    tgt_r, tgt_nxt;
  logic [IW-1:0]    thr_r, thr_nxt;
  logic             all_r, all_nxt;
  logic [VAL_W-1:0] tval_r, tval_nxt;

  // finished result
  logic             res_hit_r, res_hit_nxt;
  logic [VAL_W-1:0] res_rd_r, res_rd_nxt;
  logic             res_ev_r, res_ev_nxt;
  logic [KEY_W-1:0] res_evk_r, res_evk_nxt;

  // output register
  logic             out_vld_r, out_vld_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [VAL_W-1:0] out_rd_r, out_rd_nxt;
  logic             out_ev_r, out_ev_nxt;
  logic [KEY_W-1:0] out_evk_r, out_evk_nxt;

  // slot RAM
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  logic [WW-1:0]    mem_wd;
  logic [WW-1:0]    mem_q;
  logic [KEY_W-1:0] q_key;
  logic [VAL_W-1:0] q_val;
  logic [IW-1:0]    q_age;
  logic             q_valid;

  // register port
  logic             cfg_we;
  logic [CAP_W-1:0] cap_wr;

  assign q_age   = mem_q[IW-1:0];
  assign q_val   = mem_q[IW +: VAL_W];
  assign q_key   = mem_q[IW+VAL_W +: KEY_W];
  assign q_valid = valid_r[rd_idx_r];

  assign issue   = (cnt_r < CW'(ENTRIES));

  lkvc_slot_ram #(
    .DEPTH (ENTRIES),
    .AW    (IW),
    .DW    (WW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (cnt_r[IW-1:0]),
    .rdata (mem_q)
  );

  // register port: writes complete in the access phase, no wait states
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? CFG_DW'(cap_r) : '0;

  always_comb begin
    cap_wr = cfg_pwdata[CAP_W-1:0];
    if (cap_wr == '0) begin
      cap_wr = CAP_W'(1);
    end
  end

  always_comb begin
    cap_nxt = cap_r;
    // capacity only moves while the cache is empty
    if (cfg_we && cfg_paddr[2] == REG_CAPACITY && count_r == '0) begin
      if (32'(cap_wr) > 32'(ENTRIES)) begin
        cap_nxt = CW'(ENTRIES);
      end else begin
        cap_nxt = CW'(cap_wr);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    cnt_nxt      = cnt_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = cnt_r[IW-1:0];
    valid_nxt    = valid_r;
    count_nxt    = count_r;
    found_nxt    = found_r;
    fidx_nxt     = fidx_r;
    fval_nxt     = fval_r;
    fage_nxt     = fage_r;
    free_vld_nxt = free_vld_r;
    free_idx_nxt = free_idx_r;
    old_vld_nxt  = old_vld_r;
    oidx_nxt     = oidx_r;
    oage_nxt     = oage_r;
    okey_nxt     = okey_r;
    tgt_nxt      = tgt_r;
    thr_nxt      = thr_r;
    all_nxt      = all_r;
    tval_nxt     = tval_r;
    res_hit_nxt  = res_hit_r;
    res_rd_nxt   = res_rd_r;
    res_ev_nxt   = res_ev_r;
    res_evk_nxt  = res_evk_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_hit_nxt  = out_hit_r;
    out_rd_nxt   = out_rd_r;
    out_ev_nxt   = out_ev_r;
    out_evk_nxt  = out_evk_r;
    mem_we       = 1'b0;
    mem_wa       = rd_idx_r;
    mem_wd       = mem_q;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser;
          key_nxt      = in_tdata[KEY_W-1:0];
          val_nxt      = in_tdata[KEY_W +: VAL_W];
          cnt_nxt      = '0;
          found_nxt    = 1'b0;
          free_vld_nxt = 1'b0;
          old_vld_nxt  = 1'b0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (issue) begin
          cnt_nxt    = cnt_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          if (q_valid) begin
            // first matching key wins
            if (!found_r && q_key == key_r) begin
              found_nxt = 1'b1;
              fidx_nxt  = rd_idx_r;
              fval_nxt  = q_val;
              fage_nxt  = q_age;
            end
            // oldest valid slot, first one on a tie
            if (!old_vld_r || q_age > oage_r) begin
              old_vld_nxt = 1'b1;
              oidx_nxt    = rd_idx_r;
              oage_nxt    = q_age;
              okey_nxt    = q_key;
            end
          end else if (!free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end else if (!issue) begin
          // every slot seen: decide the outcome
          res_hit_nxt = 1'b0;
          res_rd_nxt  = '0;
          res_ev_nxt  = 1'b0;
          res_evk_nxt = '0;
          all_nxt     = 1'b0;
          tval_nxt    = val_r;
          cnt_nxt     = '0;
          state_nxt   = S_RESP;
          if (found_r) begin
            // hit on get or put: promote the slot
            res_hit_nxt = 1'b1;
            tgt_nxt     = fidx_r;
            thr_nxt     = fage_r;
            state_nxt   = S_UPD;
            if (op_r == OP_GET) begin
              res_rd_nxt = fval_r;
              tval_nxt   = fval_r;
            end
          end else if (op_r == OP_GET) begin
            res_rd_nxt = MISS_VALUE;
          end else if (count_r < cap_r && free_vld_r) begin
            // insert into a free slot, everybody else grows older
            tgt_nxt              = free_idx_r;
            all_nxt              = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
            count_nxt            = count_r + CW'(1);
            state_nxt            = S_UPD;
          end else if (old_vld_r) begin
            // cache full: replace the least recent slot
            res_ev_nxt  = 1'b1;
            res_evk_nxt = okey_r;
            tgt_nxt     = oidx_r;
            thr_nxt     = oage_r;
            state_nxt   = S_UPD;
          end
        end
      end

      S_UPD: begin
        if (issue) begin
          cnt_nxt    = cnt_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          mem_we = 1'b1;
          if (rd_idx_r == tgt_r) begin
            mem_wd = {key_r, tval_r, IW'(0)};
          end else if (q_valid && (all_r || q_age < thr_r)) begin
            mem_wd = {q_key, q_val, q_age + IW'(1)};
          end
          if (!issue) begin
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        // hand the result over once the output register is free
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_hit_nxt = res_hit_r;
          out_rd_nxt  = res_rd_r;
          out_ev_nxt  = res_ev_r;
          out_evk_nxt = res_evk_r;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      valid_r    <= '0;
      count_r    <= '0;
      cap_r      <= CW'(CAP_RST);
      found_r    <= 1'b0;
      free_vld_r <= 1'b0;
      old_vld_r  <= 1'b0;
      all_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      valid_r    <= valid_nxt;
      count_r    <= count_nxt;
      cap_r      <= cap_nxt;
      found_r    <= found_nxt;
      free_vld_r <= free_vld_nxt;
      old_vld_r  <= old_vld_nxt;
      all_r      <= all_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    rd_idx_r   <= rd_idx_nxt;
    fidx_r     <= fidx_nxt;
    fval_r     <= fval_nxt;
    fage_r     <= fage_nxt;
    free_idx_r <= free_idx_nxt;
    oidx_r     <= oidx_nxt;
    oage_r     <= oage_nxt;
    okey_r     <= okey_nxt;
    tgt_r      <= tgt_nxt;
    thr_r      <= thr_nxt;
    tval_r     <= tval_nxt;
    res_hit_r  <= res_hit_nxt;
    res_rd_r   <= res_rd_nxt;
    res_ev_r   <= res_ev_nxt;
    res_evk_r  <= res_evk_nxt;
    out_hit_r  <= out_hit_nxt;
    out_rd_r   <= out_rd_nxt;
    out_ev_r   <= out_ev_nxt;
    out_evk_r  <= out_evk_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_evk_r, out_rd_r};
  assign out_tuser  = {out_ev_r, out_hit_r};

endmodule
`default_nettype wire

### design/lkvc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lkvc_checker
  import lkvc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // result held until taken
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // one item at a time: busy right after an accept
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "accepted while busy")

  // an eviction only comes from a put that missed
  `CHK_IMPLY(a_evict_no_hit, clk, rst_n, out_tvalid && out_tuser[1], !out_tuser[0], "eviction on a hit")

  // no eviction means no evicted key
  `CHK_IMPLY(a_evk_zero, clk, rst_n, out_tvalid && !out_tuser[1], out_tdata[63:32] == '0, "stray evicted key")

  // a miss reads either zero (put) or the miss marker (get)
  `CHK_IMPLY(a_miss_value, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[31:0] == '0 || out_tdata[31:0] == MISS_VALUE, "bad read value on a miss")

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
